[rtl/core/afc_pkg.sv]
// Package for the box frustum cull core: widths, request codes, FSM states.
// No dependencies.
`default_nettype none
package afc_pkg;
    localparam int NUM_PLANES_DEF = 6;
    localparam int FRAC_BITS_DEF  = 16;
    localparam int WORD_W         = 32;

    typedef enum logic [1:0] {
        REQ_PLANE  = 2'd0,
        REQ_MATRIX = 2'd1,
        REQ_TEST   = 2'd2,
        REQ_NONE   = 2'd3
    } req_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_XRD,
        ST_XMUL,
        ST_XSUM,
        ST_PRD,
        ST_PMUL,
        ST_PSUM,
        ST_DONE
    } state_t;
endpackage
`default_nettype wire

[rtl/core/aabb_frustum_cull_core.sv]
// Box frustum cull core: plane and matrix stores in memories, one shared
// multiplier, sequencer for transform and plane tests. Depends on afc_pkg.
//
// Usage:
// One input channel (valid/ready) carries load and test requests; one output
// channel (valid/ready) carries the visible flag, only for test requests.
// A plane load (req_type 0) writes four words, a matrix row load (req_type 1)
// three words; neither gives a result. Out-of-range slots and req_type 3
// are dropped.
// A test (req_type 2) works corner by corner. Each term is a memory read, a
// multiply and an accumulate; a coordinate is four terms (three products,
// then translation) and a plane is four terms (three products, then d).
// All terms share the single 32x32 multiplier and the one-word read port;
// every plane is run for every corner. The core takes no new item until
// the test has put its flag in the output register.
// While the receiver stalls the result waits in the output register; loads
// and one more test are still taken, and that test holds in its final state
// until the waiting result is transferred. Reset clears the sequencer and
// output valid; the memories are not cleared and must be written before use.
`default_nettype none
module aabb_frustum_cull_core
    import afc_pkg::*;
#(
    parameter int NUM_PLANES = NUM_PLANES_DEF,
    parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                in_valid,
    output logic                     in_ready,
    input  wire logic [1:0]          req_type,
    input  wire logic [2:0]          slot,
    input  wire logic signed [31:0]  coef_0,
    input  wire logic signed [31:0]  coef_1,
    input  wire logic signed [31:0]  coef_2,
    input  wire logic signed [31:0]  coef_3,
    input  wire logic signed [31:0]  box_min_x,
    input  wire logic signed [31:0]  box_min_y,
    input  wire logic signed [31:0]  box_min_z,
    input  wire logic signed [31:0]  box_max_x,
    input  wire logic signed [31:0]  box_max_y,
    input  wire logic signed [31:0]  box_max_z,
    output logic                     out_valid,
    input  wire logic                out_ready,
    output logic                     visible
);
    localparam int PW  = (NUM_PLANES > 1) ? $clog2(NUM_PLANES) : 1;
    localparam int ACC_W = 68;

    // plane memory: one word per entry, written four-wide as four banks
    logic [WORD_W-1:0] plane_mem [4][NUM_PLANES];
    logic [WORD_W-1:0] mat_mem   [3][4];
    logic [WORD_W-1:0] prd_reg;
    logic [WORD_W-1:0] mrd_reg;

    state_t state_reg, state_next;
    logic [2:0]  corner_reg, corner_next;
    logic [1:0]  col_reg, col_next;
    logic [1:0]  term_reg, term_next;
    logic [PW-1:0] plane_reg, plane_next;
    logic [NUM_PLANES-1:0] seen_reg, seen_next;
    logic signed [WORD_W-1:0] bmin_reg [3];
    logic signed [WORD_W-1:0] bmax_reg [3];
    logic signed [WORD_W-1:0] wc_reg [3];
    logic signed [WORD_W-1:0] wc_next [3];
    logic signed [63:0] prod_reg;
    logic signed [ACC_W-1:0] acc_reg, acc_next;
    logic out_valid_next;
    logic vis_next;
    logic signed [WORD_W-1:0] mul_a;
    logic signed [WORD_W-1:0] mul_b;
    logic signed [ACC_W-1:0] xsum;
    logic signed [ACC_W-1:0] xsat;
    logic [1:0] rd_bank;
    logic [1:0] rd_row;
    logic accept;

    assign in_ready = (state_reg == ST_IDLE);
    assign accept   = in_valid && in_ready;

    // store writes
    always_ff @(posedge clk)
    begin
        if (accept && req_type == REQ_PLANE && {29'd0, slot} < NUM_PLANES)
        begin
            plane_mem[0][slot[PW-1:0]] <= coef_0;
            plane_mem[1][slot[PW-1:0]] <= coef_1;
            plane_mem[2][slot[PW-1:0]] <= coef_2;
            plane_mem[3][slot[PW-1:0]] <= coef_3;
        end
        if (accept && req_type == REQ_MATRIX && slot < 3'd4)
        begin
            mat_mem[0][slot[1:0]] <= coef_0;
            mat_mem[1][slot[1:0]] <= coef_1;
            mat_mem[2][slot[1:0]] <= coef_2;
        end
    end

    // registered reads, one word each per cycle
    assign rd_bank = term_reg;
    assign rd_row  = term_reg;
    always_ff @(posedge clk)
    begin
        prd_reg <= plane_mem[rd_bank][plane_reg];
        mrd_reg <= mat_mem[col_reg][rd_row];
    end

    // multiplier operands: corner coordinate and matrix word, or
    // transformed coordinate and plane word
    always_comb
    begin
        if (state_reg == ST_XMUL)
        begin
            unique case (term_reg)
                2'd0:    mul_a = corner_reg[2] ? bmax_reg[0] : bmin_reg[0];
                2'd1:    mul_a = corner_reg[0] ? bmax_reg[1] : bmin_reg[1];
                default: mul_a = corner_reg[1] ? bmax_reg[2] : bmin_reg[2];
            endcase
        end
        else
            mul_a = wc_reg[term_reg < 2'd3 ? term_reg : 2'd0];
    end
    assign mul_b = (state_reg == ST_XMUL) ? $signed(mrd_reg) : $signed(prd_reg);

    // transform sum: floor of product sum, plus translation, saturated
    assign xsum = (acc_reg >>> FRAC_BITS)
        + $signed({{(ACC_W-WORD_W){mrd_reg[WORD_W-1]}}, mrd_reg});
    always_comb
    begin
        if (xsum > ACC_W'(64'sh7FFFFFFF))
            xsat = ACC_W'(64'sh7FFFFFFF);
        else if (xsum < -ACC_W'(64'sh80000000))
            xsat = -ACC_W'(64'sh80000000);
        else
            xsat = xsum;
    end

    always_comb
    begin
        state_next     = state_reg;
        corner_next    = corner_reg;
        col_next       = col_reg;
        term_next      = term_reg;
        plane_next     = plane_reg;
        seen_next      = seen_reg;
        acc_next       = acc_reg;
        out_valid_next = out_valid;
        vis_next       = visible;
        for (int i = 0; i < 3; i++)
            wc_next[i] = wc_reg[i];
        if (out_valid && out_ready)
            out_valid_next = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept && req_type == REQ_TEST)
                begin
                    state_next  = ST_XRD;
                    corner_next = '0;
                    col_next    = '0;
                    term_next   = '0;
                    acc_next    = '0;
                    seen_next   = '0;
                end
            end
            ST_XRD:  state_next = ST_XMUL;
            ST_XMUL:
            begin
                // product ready in prod_reg next cycle
                state_next = ST_XSUM;
            end
            ST_XSUM:
            begin
                if (term_reg == 2'd3)
                begin
                    wc_next[col_reg] = xsat[WORD_W-1:0];
                    acc_next = '0;
                    term_next = '0;
                    if (col_reg == 2'd2)
                    begin
                        col_next   = '0;
                        plane_next = '0;
                        state_next = ST_PRD;
                    end
                    else
                    begin
                        col_next   = col_reg + 2'd1;
                        state_next = ST_XRD;
                    end
                end
                else
                begin
                    acc_next  = acc_reg + ACC_W'(prod_reg);
                    term_next = term_reg + 2'd1;
                    state_next = ST_XRD;
                end
            end
            ST_PRD:  state_next = ST_PMUL;
            ST_PMUL: state_next = ST_PSUM;
            ST_PSUM:
            begin
                if (term_reg == 2'd3)
                begin
                    acc_next = acc_reg
                        + (ACC_W'($signed(prd_reg)) <<< FRAC_BITS);
                    term_next = '0;
                    state_next = ST_PRD;
                end
                else
                begin
                    acc_next  = acc_reg + ACC_W'(prod_reg);
                    term_next = term_reg + 2'd1;
                    state_next = ST_PRD;
                end
            end
            ST_DONE:
            begin
                // result goes out once the output register is free
                if (!out_valid || out_ready)
                begin
                    out_valid_next = 1'b1;
                    vis_next       = &seen_reg;
                    state_next     = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
        // plane finish handled by the wrap check below
        if (state_reg == ST_PSUM && term_reg == 2'd3)
        begin
            if (!acc_next[ACC_W-1])
                seen_next[plane_reg] = 1'b1;
            acc_next = '0;
            if (32'(plane_reg) == NUM_PLANES - 1)
            begin
                plane_next = '0;
                if (corner_reg == 3'd7)
                    state_next = ST_DONE;
                else
                begin
                    corner_next = corner_reg + 3'd1;
                    state_next  = ST_XRD;
                end
            end
            else
                plane_next = plane_reg + PW'(1);
        end
    end

    // shared multiplier, registered
    always_ff @(posedge clk)
    begin
        prod_reg <= mul_a * mul_b;
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            bmin_reg[0] <= box_min_x;
            bmin_reg[1] <= box_min_y;
            bmin_reg[2] <= box_min_z;
            bmax_reg[0] <= box_max_x;
            bmax_reg[1] <= box_max_y;
            bmax_reg[2] <= box_max_z;
        end
        for (int i = 0; i < 3; i++)
            wc_reg[i] <= wc_next[i];
        acc_reg <= acc_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            corner_reg <= '0;
            col_reg    <= '0;
            term_reg   <= '0;
            plane_reg  <= '0;
            seen_reg   <= '0;
            out_valid  <= 1'b0;
            visible    <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            corner_reg <= corner_next;
            col_reg    <= col_next;
            term_reg   <= term_next;
            plane_reg  <= plane_next;
            seen_reg   <= seen_next;
            out_valid  <= out_valid_next;
            visible    <= vis_next;
        end
    end

    // checks
    a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != ST_IDLE) |-> !in_ready) else $error("accept while busy");
    a_done_out: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DONE && (!out_valid || out_ready))
        |=> (out_valid && state_reg == ST_IDLE)) else $error("done without result");
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> (out_valid && $stable(visible)))
        else $error("result changed while stalled");
    a_plane_range: assert property (@(posedge clk) disable iff (!rst_n)
        32'(plane_reg) < NUM_PLANES) else $error("plane index out of range");
endmodule
`default_nettype wire
